[hdl/vhd_pkg.sv]
// Package for the vector heading core: shared widths, defaults, constants,
// the CORDIC arctangent table and the pipeline sideband type.
// Used by the channel interfaces, the core and the checker.
`default_nettype none

package vhd_pkg;

	// Default values of the top-level parameters.
	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int CORDIC_STAGES_DEF   = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 4;

	// Heading field width, fixed by the output word format.
	localparam int HEADING_BITS = 13;

	// Magnitudes are shifted left by a fixed amount so that full scale lands at 2^47.
	localparam int NORM_BITS = 48;
	// CORDIC x/y width: normalized magnitude times gain and sqrt(2), plus sign.
	localparam int CORDIC_W  = 51;
	// Angle accumulator width in nanodegrees, signed (table sum is under 2^37).
	localparam int ANGLE_W   = 38;
	// Width of the folded angle plus rounding bias (under 361e9).
	localparam int NUM_W     = 39;
	// Number of table entries available.
	localparam int ATAN_LEN  = 24;

	localparam longint NANO_PER_DEG = 64'd1_000_000_000;
	localparam longint NANO_90      = 64'd90_000_000_000;
	localparam longint NANO_180     = 64'd180_000_000_000;
	localparam longint NANO_360     = 64'd360_000_000_000;

	// Quadrant of the input vector.
	typedef struct packed {
		logic neg_x;
		logic neg_y;
	} vhd_quad_t;

	// Sideband that travels with each word through the pipeline.
	typedef struct packed {
		logic                    zero;     // both samples zero
		logic                    on_axis;  // exact result, CORDIC bypassed
		logic [HEADING_BITS-1:0] axis_hdg; // exact heading for the axis case
		vhd_quad_t               quad;
	} vhd_side_t;

	// atan(2^-i) in nanodegrees, rounded to nearest.
	function automatic logic [ANGLE_W-1:0] atan_nano(input logic [4:0] idx);
		logic [ANGLE_W-1:0] r;
		case (idx)
			5'd0:    r = 38'd45000000000;
			5'd1:    r = 38'd26565051177;
			5'd2:    r = 38'd14036243468;
			5'd3:    r = 38'd7125016349;
			5'd4:    r = 38'd3576334375;
			5'd5:    r = 38'd1789910608;
			5'd6:    r = 38'd895173710;
			5'd7:    r = 38'd447614171;
			5'd8:    r = 38'd223810500;
			5'd9:    r = 38'd111905677;
			5'd10:   r = 38'd55952892;
			5'd11:   r = 38'd27976453;
			5'd12:   r = 38'd13988227;
			5'd13:   r = 38'd6994114;
			5'd14:   r = 38'd3497057;
			5'd15:   r = 38'd1748528;
			5'd16:   r = 38'd874264;
			5'd17:   r = 38'd437132;
			5'd18:   r = 38'd218566;
			5'd19:   r = 38'd109283;
			5'd20:   r = 38'd54642;
			5'd21:   r = 38'd27321;
			5'd22:   r = 38'd13660;
			5'd23:   r = 38'd6830;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/vhd_if.sv]
// Valid/ready channel interfaces for the vector heading core:
// the sample pair input channel and the heading result channel.
// Depends on vhd_pkg for default widths and the heading width.
`default_nettype none

interface vhd_in_if #(
	parameter int SAMPLE_BITS = vhd_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] x_field;
	logic signed [SAMPLE_BITS-1:0] y_field;

	modport source (output valid, output x_field, output y_field, input ready);
	modport sink   (input valid, input x_field, input y_field, output ready);
endinterface

interface vhd_out_if;
	logic                              valid;
	logic                              ready;
	logic [vhd_pkg::HEADING_BITS-1:0]  heading;
	logic                              zero_vector;

	modport source (output valid, output heading, output zero_vector, input ready);
	modport sink   (input valid, input heading, input zero_vector, output ready);
endinterface

`default_nettype wire

[hdl/vector_heading_degrees_core.sv]
// Vector heading core: pipelined CORDIC atan2 of a signed X/Y sample pair.
// Depends on vhd_pkg and the channel interfaces in vhd_if.sv.
//
// The core takes one sample word per clock and returns one heading word per
// sample, in order, as the angle counter-clockwise from +X in units of
// 2^-ANGLE_FRAC_BITS degree (0 to just under 360 degrees). Samples on an axis
// give exact results; a zero vector gives heading 0 with zero_vector set.
// From input word to result word a sample passes the input register, one
// stage per CORDIC micro-rotation, the clamp and fold registers, two stages
// for the reciprocal multiplication that scales nanodegrees to output units,
// and the output register. One word per cycle is taken while the result
// channel does not stall. A stalled result freezes the
// whole pipeline, so sample.ready is low exactly while a result is waiting and
// result.ready is low.
`default_nettype none

module vector_heading_degrees_core #(
	parameter int SAMPLE_BITS     = vhd_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STAGES   = vhd_pkg::CORDIC_STAGES_DEF,
	parameter int ANGLE_FRAC_BITS = vhd_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	vhd_in_if.sink     sample,
	vhd_out_if.source  result
);
	import vhd_pkg::*;

	// Derived sizes and constants.
	localparam int     NORM_SHIFT = NORM_BITS - SAMPLE_BITS;
	localparam longint FULL_UNITS = 64'd360 << ANGLE_FRAC_BITS;
	localparam int     QUOT_BITS  = $clog2(FULL_UNITS + 1);
	localparam longint BIAS       = (NANO_PER_DEG / 2) >> ANGLE_FRAC_BITS;
	localparam int     NUM_STAGES = CORDIC_STAGES + 5;

	// Nanodegrees per output unit is 2^(9-ANGLE_FRAC_BITS) * 5^9. The power of two
	// is dropped from the numerator, and the odd part is divided out exactly by a
	// rounded-up reciprocal with one guard bit per numerator bit.
	localparam int     DIV_SHIFT  = 9 - ANGLE_FRAC_BITS;
	localparam longint DIV_ODD    = 64'd1_953_125;
	localparam int     RED_W      = NUM_W - DIV_SHIFT;
	localparam int     RECIP_SH   = RED_W + 21;
	localparam longint RECIP      = ((64'd1 << RECIP_SH) + DIV_ODD - 1) / DIV_ODD;
	localparam int     RECIP_W    = RED_W + 1;
	localparam int     LO_W       = 17;
	localparam int     HI_W       = RED_W - LO_W;
	localparam int     PP_LO_W    = LO_W + RECIP_W;
	localparam int     PP_HI_W    = HI_W + RECIP_W;
	localparam int     PROD_W     = RED_W + RECIP_W;

	localparam logic [HEADING_BITS-1:0] HDG_90  = HEADING_BITS'(64'd90 << ANGLE_FRAC_BITS);
	localparam logic [HEADING_BITS-1:0] HDG_180 = HEADING_BITS'(64'd180 << ANGLE_FRAC_BITS);
	localparam logic [HEADING_BITS-1:0] HDG_270 = HEADING_BITS'(64'd270 << ANGLE_FRAC_BITS);
	localparam logic signed [ANGLE_W-1:0] Z_MAX = ANGLE_W'(NANO_90);
	localparam logic [NUM_W-1:0] FOLD_Q1 = NUM_W'(BIAS);
	localparam logic [NUM_W-1:0] FOLD_Q2 = NUM_W'(NANO_180 + BIAS);
	localparam logic [NUM_W-1:0] FOLD_Q4 = NUM_W'(NANO_360 + BIAS);
	localparam logic [QUOT_BITS-1:0] QUOT_FULL = QUOT_BITS'(FULL_UNITS);
	localparam logic [RECIP_W-1:0]   RECIP_K   = RECIP_W'(RECIP);

	// Pipeline control: the whole pipeline moves when the output can take a word.
	logic      adv;
	logic      v_s  [0:NUM_STAGES-1];
	vhd_side_t sb_s [0:NUM_STAGES-1];
	logic      out_valid_q;

	assign adv          = !out_valid_q || result.ready;
	assign sample.ready = adv;

	// Input decode: special cases, quadrant and normalized magnitudes.
	logic                   x_neg, y_neg, x_zero, y_zero;
	logic [SAMPLE_BITS-1:0] mag_x, mag_y;
	vhd_side_t              side_in;

	assign x_neg  = sample.x_field[SAMPLE_BITS-1];
	assign y_neg  = sample.y_field[SAMPLE_BITS-1];
	assign x_zero = (sample.x_field == '0);
	assign y_zero = (sample.y_field == '0);
	assign mag_x  = x_neg ? (~sample.x_field + 1'b1) : sample.x_field;
	assign mag_y  = y_neg ? (~sample.y_field + 1'b1) : sample.y_field;

	always_comb begin
		side_in.zero       = x_zero && y_zero;
		side_in.on_axis    = x_zero || y_zero;
		side_in.quad.neg_x = x_neg;
		side_in.quad.neg_y = y_neg;
		if (y_zero) begin
			side_in.axis_hdg = x_neg ? HDG_180 : '0;
		end else begin
			side_in.axis_hdg = y_neg ? HDG_270 : HDG_90;
		end
	end

	// Valid bits and sideband ride along the full depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k < NUM_STAGES; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	// CORDIC vectoring: index 0 is the input register, index i+1 follows rotation i.
	logic signed [CORDIC_W-1:0] x_s [0:CORDIC_STAGES];
	logic signed [CORDIC_W-1:0] y_s [0:CORDIC_STAGES];
	logic signed [ANGLE_W-1:0]  z_s [0:CORDIC_STAGES];

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= $signed({{(CORDIC_W - SAMPLE_BITS){1'b0}}, mag_x} << NORM_SHIFT);
			y_s[0] <= $signed({{(CORDIC_W - SAMPLE_BITS){1'b0}}, mag_y} << NORM_SHIFT);
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		localparam logic signed [ANGLE_W-1:0] ATAN_I = $signed(atan_nano(5'(i)));

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!y_s[i][CORDIC_W-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_I;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_I;
				end
			end
		end
	end

	// Clamp the first-quadrant angle to 0..90 degrees.
	logic [ANGLE_W-2:0] theta_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (z_s[CORDIC_STAGES][ANGLE_W-1]) begin
				theta_s <= '0;
			end else if (z_s[CORDIC_STAGES] > Z_MAX) begin
				theta_s <= Z_MAX[ANGLE_W-2:0];
			end else begin
				theta_s <= z_s[CORDIC_STAGES][ANGLE_W-2:0];
			end
		end
	end

	// Quadrant fold with the rounding bias folded into the base constant.
	logic [NUM_W-1:0]     fold_base;
	logic                 fold_sub;
	logic [NUM_W-1:0]     theta_ext;
	vhd_quad_t            quad_f;

	assign quad_f    = sb_s[CORDIC_STAGES + 1].quad;
	assign theta_ext = NUM_W'(theta_s);

	always_comb begin
		case ({quad_f.neg_x, quad_f.neg_y})
			2'b00: begin
				fold_base = FOLD_Q1;
				fold_sub  = 1'b0;
			end
			2'b10: begin
				fold_base = FOLD_Q2;
				fold_sub  = 1'b1;
			end
			2'b11: begin
				fold_base = FOLD_Q2;
				fold_sub  = 1'b0;
			end
			default: begin
				fold_base = FOLD_Q4;
				fold_sub  = 1'b1;
			end
		endcase
	end

	logic [NUM_W-1:0] num_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s <= fold_sub ? (fold_base - theta_ext) : (fold_base + theta_ext);
		end
	end

	// Scale to output units: two partial products of the reduced numerator and the
	// reciprocal, then their sum, whose upper bits are the rounded heading.
	logic [RED_W-1:0]     red_n;
	logic [PP_LO_W-1:0]   pp_lo_s;
	logic [PP_HI_W-1:0]   pp_hi_s;
	logic [PROD_W-1:0]    prod_sum;
	logic [QUOT_BITS-1:0] quot_s;

	assign red_n    = num_s[NUM_W-1:DIV_SHIFT];
	assign prod_sum = PROD_W'(pp_lo_s) + (PROD_W'(pp_hi_s) << LO_W);

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_lo_s <= PP_LO_W'(red_n[LO_W-1:0]) * PP_LO_W'(RECIP_K);
			pp_hi_s <= PP_HI_W'(red_n[RED_W-1:LO_W]) * PP_HI_W'(RECIP_K);
			quot_s  <= prod_sum[RECIP_SH +: QUOT_BITS];
		end
	end

	// Output register: wrap a full circle to zero and select the exact axis result.
	logic [QUOT_BITS-1:0]    quot_wrap;
	vhd_side_t               sb_last;
	logic [HEADING_BITS-1:0] heading_q;
	logic                    zero_q;

	assign sb_last   = sb_s[NUM_STAGES-1];
	assign quot_wrap = (quot_s == QUOT_FULL) ? '0 : quot_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s[NUM_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			heading_q <= sb_last.on_axis ? sb_last.axis_hdg : HEADING_BITS'(quot_wrap);
			zero_q    <= sb_last.zero;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.heading     = heading_q;
	assign result.zero_vector = zero_q;

	// The dropped numerator bits and the product bits outside the quotient are not needed.
	logic unused_bits;
	assign unused_bits = ^{num_s[DIV_SHIFT-1:0], prod_sum[RECIP_SH-1:0],
		prod_sum[PROD_W-1:RECIP_SH+QUOT_BITS]};

endmodule

`default_nettype wire

[hdl/vhd_check.sv]
// Port-level checker for the vector heading core, and its bind statement.
// Depends on vhd_pkg; attaches to vector_heading_degrees_core.
`default_nettype none

module vhd_check #(
	parameter int ANGLE_FRAC_BITS = vhd_pkg::ANGLE_FRAC_BITS_DEF
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             sample_ready,
	input wire logic                             result_valid,
	input wire logic                             result_ready,
	input wire logic [vhd_pkg::HEADING_BITS-1:0] heading,
	input wire logic                             zero_vector
);
	import vhd_pkg::*;

	localparam longint FULL_UNITS = 64'd360 << ANGLE_FRAC_BITS;
	localparam logic   NARROW     = (ANGLE_FRAC_BITS <= 4);
	localparam logic [HEADING_BITS:0] FULL_HDG = (HEADING_BITS + 1)'(FULL_UNITS);

	// A zero vector always reports heading zero.
	a_zero_heading: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && zero_vector |-> heading == '0)
		else $error("zero vector word with nonzero heading");

	// With the narrow angle format the heading stays below a full circle.
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && NARROW |-> {1'b0, heading} < FULL_HDG)
		else $error("heading at or above a full circle");

	// The input is held back exactly while a result waits to be taken.
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready == (!result_valid || result_ready))
		else $error("input ready does not follow output stall");

	// A waiting result stays valid and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
		result_valid && $stable(heading) && $stable(zero_vector))
		else $error("stalled result word changed");

endmodule

bind vector_heading_degrees_core vhd_check #(
	.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_vhd_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.heading      (result.heading),
	.zero_vector  (result.zero_vector)
);

`default_nettype wire
